// ----- rtl/bra_pkg.sv -----
// Shared types and constants for the bitmap run allocator.
`default_nettype none
package bra_pkg;

    localparam int UNITS_PER_BYTE = 8;
    localparam int WORD_BITS      = 32;
    localparam int WORD_SHIFT     = 5;
    localparam int INDEX_W        = 10;
    localparam int RUN_W          = 11;
    localparam logic [7:0] BYTES_RESET = 8'd128;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_SCAN  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ACCESS,
        ST_SCAN
    } bra_state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [INDEX_W-1:0] bit_index;
        logic               bit_value;
        logic [RUN_W-1:0]   run_length;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] start_index;
        logic               bit_state;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/bra_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/bitmap_run_allocator.sv -----
// Top level of the bitmap run allocator: command sequencer around one map RAM.
//
// Usage: present a request and pulse start while busy is low; the request is
// taken at that edge. Each request gives one result on result, marked by done
// for exactly one cycle; the receiver cannot hold it off, so sample it then.
// The map is packed into 32-bit RAM words, unit u at word u/32, bit u%32.
// Steps, from the accepting edge to the edge that ends the done cycle:
//   test / write in range : read word, then report or write back
//   test / write out of range, scan with run length 0 or too long : reported from idle
//   clear : every map word zeroed in turn (one word zeroed per cycle), then done
//   scan  : one 32-bit word is examined per cycle, set by the single RAM read
//           port, until a run is found or the last managed word is examined
// A new request may be accepted in the same cycle that done is high.
// cfg_we / cfg_wdata set bytes_in_use (reset 128); write it only while idle.
// After reset the block clears the map, one word per cycle, holding busy high
// until every word is zeroed, before the first request is taken.
`default_nettype none
module bitmap_run_allocator #(
    parameter int MAP_BYTES = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bra_pkg::request_t request,
    output logic                   done,
    output bra_pkg::result_t       result,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata
);

    localparam int WORDS = (MAP_BYTES + 3) / 4;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int EXT_W = (((AW + 5) > 11) ? (AW + 5) : 11) + 1;
    localparam int WB    = bra_pkg::WORD_BITS;

    bra_pkg::bra_state_t state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                clr_report_reg, clr_report_next;
    logic [AW-1:0]       proc_addr_reg, proc_addr_next;
    logic [10:0]         carry_reg, carry_next;
    logic [7:0]          bytes_reg, bytes_next;
    logic                done_reg, done_next;
    bra_pkg::request_t   req_reg, req_next;
    bra_pkg::result_t    result_reg, result_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WB-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WB-1:0]       ram_rdata;

    logic [EXT_W-1:0]    eff_bytes;
    logic [EXT_W-1:0]    total_units;
    logic [EXT_W-1:0]    total_m1;
    logic [AW-1:0]       last_word;
    logic [EXT_W-1:0]    in_idx_ext;
    logic [EXT_W-1:0]    req_idx_ext;
    logic [EXT_W-1:0]    base_unit;
    logic                is_last;
    logic [WB-1:0]       scan_word;
    logic [5:0]          lo_pos [WB];
    logic [11:0]         run_len [WB];
    logic [WB-1:0]       hit;
    logic                any_hit;
    logic [4:0]          hit_pos;
    logic [EXT_W-1:0]    hit_start;
    logic [11:0]         tail_len;

    // position plus one of the highest set bit in w[upto:0], zero if none
    function automatic logic [5:0] last_one(input logic [31:0] w, input int upto);
        logic [5:0] res;
        res = 6'd0;
        for (int j = 0; j < 32; j++)
        begin
            if (j <= upto && w[j])
            begin
                res = 6'(j + 1);
            end
        end
        return res;
    endfunction

    bra_ram #(
        .WIDTH(WB),
        .DEPTH(WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Managed extent of the map
    always_comb
    begin
        if (EXT_W'(bytes_reg) > EXT_W'(MAP_BYTES))
        begin
            eff_bytes = EXT_W'(MAP_BYTES);
        end
        else
        begin
            eff_bytes = EXT_W'(bytes_reg);
        end
        total_units = eff_bytes << 3;
        total_m1    = total_units - EXT_W'(1);
        last_word   = total_m1[AW+4:5];
        in_idx_ext  = EXT_W'(request.bit_index);
        req_idx_ext = EXT_W'(req_reg.bit_index);
        base_unit   = EXT_W'({proc_addr_reg, 5'd0});
        is_last     = (proc_addr_reg == last_word);
    end

    // Word examination for a scan: free-run length ending at every bit
    always_comb
    begin
        scan_word = ram_rdata;
        for (int i = 0; i < WB; i++)
        begin
            // units past the managed end act as used
            if (is_last && total_units[4:0] != 5'd0 && 5'(i) >= total_units[4:0])
            begin
                scan_word[i] = 1'b1;
            end
        end
        for (int i = 0; i < WB; i++)
        begin
            lo_pos[i] = last_one(scan_word, i);
            if (lo_pos[i] == 6'd0)
            begin
                run_len[i] = 12'(carry_reg) + 12'(i + 1);
            end
            else
            begin
                run_len[i] = 12'(6'(i + 1) - lo_pos[i]);
            end
            hit[i] = (run_len[i] >= {1'b0, req_reg.run_length});
        end
        any_hit = |hit;
        hit_pos = 5'd0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_pos = 5'(i);
            end
        end
        hit_start = base_unit + EXT_W'(hit_pos) + EXT_W'(1) - EXT_W'(req_reg.run_length);
        tail_len  = run_len[WB-1];
    end

    // Sequencer: next state, RAM access and result
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        proc_addr_next  = proc_addr_reg;
        carry_next      = carry_reg;
        bytes_next      = bytes_reg;
        done_next       = 1'b0;
        req_next        = req_reg;
        result_next     = result_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = '0;
        ram_raddr       = in_idx_ext[AW+4:5];

        if (cfg_we)
        begin
            bytes_next = cfg_wdata;
        end

        case (state_reg)
            bra_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next    = request;
                    result_next = '0;
                    case (request.command)
                        bra_pkg::CMD_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = bra_pkg::ST_CLEAR;
                        end
                        bra_pkg::CMD_TEST, bra_pkg::CMD_WRITE:
                        begin
                            if (in_idx_ext < total_units)
                            begin
                                state_next = bra_pkg::ST_ACCESS;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            ram_raddr = '0;
                            if (request.run_length == '0 ||
                                EXT_W'(request.run_length) > total_units)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                proc_addr_next = '0;
                                carry_next     = '0;
                                state_next     = bra_pkg::ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            bra_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == AW'(WORDS - 1))
                begin
                    done_next       = clr_report_reg;
                    clr_report_next = 1'b0;
                    state_next      = bra_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            bra_pkg::ST_ACCESS:
            begin
                // read data for the addressed word is now valid
                done_next  = 1'b1;
                state_next = bra_pkg::ST_IDLE;
                ram_raddr  = req_idx_ext[AW+4:5];
                if (req_reg.command == bra_pkg::CMD_TEST)
                begin
                    result_next.bit_state = ram_rdata[req_reg.bit_index[4:0]];
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = req_idx_ext[AW+4:5];
                    ram_wdata = ram_rdata;
                    ram_wdata[req_reg.bit_index[4:0]] = req_reg.bit_value;
                end
            end

            bra_pkg::ST_SCAN:
            begin
                // keep one word in flight: read the next while examining this one
                ram_raddr = is_last ? proc_addr_reg : proc_addr_reg + AW'(1);
                if (any_hit)
                begin
                    result_next.found       = 1'b1;
                    result_next.start_index = hit_start[bra_pkg::INDEX_W-1:0];
                    done_next               = 1'b1;
                    state_next              = bra_pkg::ST_IDLE;
                end
                else if (is_last)
                begin
                    done_next  = 1'b1;
                    state_next = bra_pkg::ST_IDLE;
                end
                else
                begin
                    proc_addr_next = proc_addr_reg + AW'(1);
                    carry_next     = tail_len[11] ? 11'h7ff : tail_len[10:0];
                end
            end

            default:
            begin
                state_next = bra_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bra_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            proc_addr_reg  <= '0;
            carry_reg      <= '0;
            bytes_reg      <= bra_pkg::BYTES_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            proc_addr_reg  <= proc_addr_next;
            carry_reg      <= carry_next;
            bytes_reg      <= bytes_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != bra_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // An accepted transaction always leaves the block busy or reporting
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction made no progress");

    // The map is only written by a clear sweep or a write-back
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bra_pkg::ST_IDLE || state_reg == bra_pkg::ST_SCAN) |-> !ram_we)
        else $error("map written outside clear or write-back");

    // A scan never walks past the last managed word
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bra_pkg::ST_SCAN) |-> (proc_addr_reg <= last_word))
        else $error("scan beyond managed words");

    // A found run lies wholly inside the managed units
    a_run_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bra_pkg::ST_SCAN && any_hit) |->
            (hit_start + EXT_W'(req_reg.run_length) <= total_units))
        else $error("found run leaves the managed map");

endmodule
`default_nettype wire

// ----- tb/bitmap_run_allocator_test.sv -----
// Self-checking testbench for the bitmap run allocator: directed table, then random phases.
module bitmap_run_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BYTES       = 128;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        bra_pkg::request_t req;
        bit                typed;
        bra_pkg::result_t  res;
    } table_row_t;

    typedef struct {
        bra_pkg::request_t req;
        bit                alloc;
    } planned_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    logic              cfg_we;
    logic [7:0]        cfg_wdata;
    bra_pkg::request_t request;
    bra_pkg::result_t  result;

    // predictor copy of the map and of the register
    logic [7:0]        alloc_map [MAP_BYTES];
    logic [7:0]        bytes_reg;
    bra_pkg::result_t  expected_q [$];
    planned_t          plan_q [$];
    table_row_t        directed_rows [$];
    int unsigned       mismatches;
    int unsigned       idle_left;
    bit                idle_quiet;

    bitmap_run_allocator #(.MAP_BYTES(MAP_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned managed_units();
        int unsigned n;
        n = (bytes_reg > MAP_BYTES) ? MAP_BYTES : bytes_reg;
        return n * 8;
    endfunction

    function automatic bra_pkg::request_t make_req(bra_pkg::cmd_t cmd, int unsigned idx,
                                                   bit val, int unsigned len);
        bra_pkg::request_t r;
        r.command    = cmd;
        r.bit_index  = idx[9:0];
        r.bit_value  = val;
        r.run_length = len[10:0];
        return r;
    endfunction

    // Work out the result of one transaction and advance the predicted map.
    function automatic bra_pkg::result_t allocator_predict(bra_pkg::request_t req);
        bra_pkg::result_t r;
        int unsigned      total;
        int unsigned      want;
        int unsigned      run;
        int unsigned      u;
        r     = '0;
        total = managed_units();
        case (req.command)
            bra_pkg::CMD_CLEAR:
            begin
                foreach (alloc_map[b])
                    alloc_map[b] = 8'h00;
            end
            bra_pkg::CMD_TEST:
            begin
                if (req.bit_index < total)
                    r.bit_state = alloc_map[req.bit_index[9:3]][req.bit_index[2:0]];
            end
            bra_pkg::CMD_WRITE:
            begin
                if (req.bit_index < total)
                    alloc_map[req.bit_index[9:3]][req.bit_index[2:0]] = req.bit_value;
            end
            default:
            begin
                want = req.run_length;
                run  = 0;
                if (want != 0 && want <= total)
                begin
                    for (u = 0; u < total && !r.found; u++)
                    begin
                        if (alloc_map[u[9:3]][u[2:0]])
                            run = 0;
                        else
                        begin
                            run++;
                            if (run == want)
                            begin
                                r.found       = 1'b1;
                                r.start_index = 10'(u + 1 - want);
                            end
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Alternate stretches with no idling and stretches with random gaps.
    function automatic int unsigned draw_gap();
        if (idle_left == 0)
        begin
            idle_left  = $urandom_range(10, 40);
            idle_quiet = ($urandom_range(0, 3) == 0);
        end
        idle_left--;
        return idle_quiet ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic int unsigned draw_index(int unsigned units);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1023);
        return $urandom_range(0, units + 7) & 1023;
    endfunction

    task automatic add_row(bra_pkg::cmd_t cmd, int unsigned idx, bit val, int unsigned len,
                           bit typed, bit f, int unsigned s, bit b);
        table_row_t row;
        row.req             = make_req(cmd, idx, val, len);
        row.typed           = typed;
        row.res.found       = f;
        row.res.start_index = s[9:0];
        row.res.bit_state   = b;
        directed_rows.push_back(row);
    endtask

    // Present one transaction, wait for it to be taken, and log what should come back.
    task automatic issue(bra_pkg::request_t req, bit typed, bra_pkg::result_t typed_res,
                         bit alloc);
        bra_pkg::result_t pred;
        int unsigned      gap;
        int unsigned      k;
        bit               pause;
        planned_t         p;
        gap   = draw_gap();
        pause = ($urandom_range(0, 59) == 0);
        if (pause && gap == 0)
            gap = 1;
        if (gap != 0)
        begin
            start <= 1'b0;
            if (pause)
                while (expected_q.size() != 0)
                    @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        request <= req;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pred = allocator_predict(req);
        expected_q.push_back(typed ? typed_res : pred);
        // mark a run that was just found, as an allocator client would
        if (alloc && pred.found)
        begin
            for (k = 0; k < req.run_length; k++)
            begin
                p.req   = make_req(bra_pkg::CMD_WRITE, pred.start_index + k, 1'b1,
                                   $urandom_range(0, 2047));
                p.alloc = 1'b0;
                plan_q.push_back(p);
            end
        end
    endtask

    task automatic plan_random();
        int unsigned units;
        int unsigned sel;
        int unsigned base;
        int unsigned len;
        int unsigned k;
        planned_t    p;
        units   = managed_units();
        sel     = $urandom_range(0, 99);
        p.alloc = 1'b0;
        if (sel < 2)
        begin
            p.req = make_req(bra_pkg::CMD_CLEAR, $urandom_range(0, 1023),
                             1'($urandom_range(0, 1)), $urandom_range(0, 2047));
            plan_q.push_back(p);
        end
        else if (sel < 25)
        begin
            p.req = make_req(bra_pkg::CMD_TEST, draw_index(units),
                             1'($urandom_range(0, 1)), $urandom_range(0, 2047));
            plan_q.push_back(p);
        end
        else if (sel < 55)
        begin
            p.req = make_req(bra_pkg::CMD_WRITE, draw_index(units),
                             $urandom_range(0, 9) < 7, $urandom_range(0, 2047));
            plan_q.push_back(p);
        end
        else if (sel < 63)
        begin
            // fill a whole byte so the scan meets fully used bytes
            base = ($urandom_range(0, units >> 3) & 127) * 8;
            for (k = 0; k < 8; k++)
            begin
                p.req = make_req(bra_pkg::CMD_WRITE, base + k, 1'b1,
                                 $urandom_range(0, 2047));
                plan_q.push_back(p);
            end
        end
        else if (sel < 73)
        begin
            // free a short run
            base = draw_index(units);
            len  = $urandom_range(1, 16);
            for (k = 0; k < len; k++)
            begin
                p.req = make_req(bra_pkg::CMD_WRITE, (base + k) & 1023, 1'b0,
                                 $urandom_range(0, 2047));
                plan_q.push_back(p);
            end
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                len     = $urandom_range(1, 16);
                p.alloc = 1'b1;
            end
            else if (sel < 80)
                len = $urandom_range(1, units + 2);
            else if (sel < 93)
                len = $urandom_range(0, 2047);
            else
            begin
                case ($urandom_range(0, 4))
                    0: len = 0;
                    1: len = units;
                    2: len = units + 1;
                    3: len = 1024;
                    default: len = 2047;
                endcase
            end
            p.req = make_req(bra_pkg::CMD_SCAN, $urandom_range(0, 1023),
                             1'($urandom_range(0, 1)), len);
            plan_q.push_back(p);
        end
    endtask

    // Drop start and hold until every result is in and the block is idle.
    task automatic settle();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic set_bytes_in_use(logic [7:0] value);
        settle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        bytes_reg = value;
        cfg_we    <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        bra_pkg::result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: found %0d start %0d bit %0d",
                         $time, result.found, result.start_index, result.bit_state);
                mismatches++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (result.found !== exp_r.found)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, exp_r.found, result.found);
                    mismatches++;
                end
                if (result.start_index !== exp_r.start_index)
                begin
                    $display("%0t: start_index expected %0d actual %0d",
                             $time, exp_r.start_index, result.start_index);
                    mismatches++;
                end
                if (result.bit_state !== exp_r.bit_state)
                begin
                    $display("%0t: bit_state expected %0d actual %0d",
                             $time, exp_r.bit_state, result.bit_state);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0]  phase_bytes [9];
        planned_t    p;
        int unsigned sent;
        int unsigned ph;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        request    <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        mismatches = 0;
        idle_left  = 0;
        idle_quiet = 1'b0;
        bytes_reg  = bra_pkg::BYTES_RESET;
        foreach (alloc_map[b])
            alloc_map[b] = 8'h00;
        phase_bytes = '{8'd0, 8'd1, 8'd255, 8'd129, 8'd2, 8'd128, 8'd37, 8'd64, 8'd0};
        phase_bytes[8] = 8'($urandom_range(1, 128));

        //      command             index val len   typed found start bit
        add_row(bra_pkg::CMD_TEST,  0,    0, 1,    1,    0,    0,    0);
        add_row(bra_pkg::CMD_TEST,  1023, 1, 0,    1,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 1,    1,    1,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  1023, 1, 1024, 1,    1,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 0,    1,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 1025, 1,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  1023, 1, 2047, 1,    0,    0,    0);
        add_row(bra_pkg::CMD_WRITE, 0,    1, 0,    1,    0,    0,    0);
        add_row(bra_pkg::CMD_WRITE, 1023, 1, 2047, 1,    0,    0,    0);
        add_row(bra_pkg::CMD_TEST,  0,    0, 0,    0,    0,    0,    0);
        add_row(bra_pkg::CMD_TEST,  1023, 0, 0,    0,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 1,    0,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 1022, 0,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 1023, 0,    0,    0,    0);
        add_row(bra_pkg::CMD_WRITE, 512,  1, 0,    0,    0,    0,    0);
        add_row(bra_pkg::CMD_WRITE, 0,    0, 0,    0,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 512,  0,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 513,  0,    0,    0,    0);
        add_row(bra_pkg::CMD_TEST,  512,  0, 0,    0,    0,    0,    0);
        add_row(bra_pkg::CMD_CLEAR, 1023, 1, 2047, 1,    0,    0,    0);
        add_row(bra_pkg::CMD_TEST,  512,  0, 0,    1,    0,    0,    0);
        add_row(bra_pkg::CMD_SCAN,  0,    0, 1024, 1,    1,    0,    0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res, 1'b0);

        for (ph = 0; ph < 9; ph++)
        begin
            plan_q.delete();
            set_bytes_in_use(phase_bytes[ph]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (plan_q.size() == 0)
                    plan_random();
                p = plan_q.pop_front();
                issue(p.req, 1'b0, '0, p.alloc);
                sent++;
            end
        end

        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
